[hw/rtl/dtf_pkg.sv]
// shared types, constants and codes for the decimal text to fixed point converter
package dtf_pkg;

  // number format
  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int MAG_BITS        = INT_BITS + FRAC_BITS;
  localparam int VALUE_BITS      = 64;
  localparam int FDIG_BITS       = 4;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_CHAR  = 2'd1,
    ERR_PLACEMENT = 2'd2
  } err_code_t;

  // input word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [1:0]                   error_code;
  } out_word_t;

  // finished string handed from the accumulator to the output stage
  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                negative;
    err_code_t           err;
  } res_t;

endpackage

[hw/rtl/dtf_in_reg.sv]
// input register for incoming character words
module dtf_in_reg
  import dtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     take,
  output logic     vld_r,
  output in_word_t word_r
);

  logic load;

  // stall only while a held word is not consumed this cycle
  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

endmodule

[hw/rtl/dtf_accum.sv]
// per-character parse state and accumulators, result register at string end
module dtf_accum
  import dtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     vld,
  input  in_word_t word,
  output logic     take,
  input  logic     res_take,
  output logic     res_vld_r,
  output res_t     res_r
);

  localparam logic [INT_BITS+3:0] INT_LIMIT = (INT_BITS+4)'((64'd1 << INT_BITS) - 64'd1);
  localparam logic [63:0] ONE_FRAC = 64'd1 << FRAC_BITS;

  // truncated weights 2^FRAC_BITS / 10^k for k = 1..9
  localparam logic [FRAC_BITS-1:0] FRAC_W [0:8] = '{
    FRAC_BITS'(ONE_FRAC / 64'd10),
    FRAC_BITS'(ONE_FRAC / 64'd100),
    FRAC_BITS'(ONE_FRAC / 64'd1000),
    FRAC_BITS'(ONE_FRAC / 64'd10000),
    FRAC_BITS'(ONE_FRAC / 64'd100000),
    FRAC_BITS'(ONE_FRAC / 64'd1000000),
    FRAC_BITS'(ONE_FRAC / 64'd10000000),
    FRAC_BITS'(ONE_FRAC / 64'd100000000),
    FRAC_BITS'(ONE_FRAC / 64'd1000000000)
  };

  logic [INT_BITS-1:0]  int_acc_r, int_acc_nxt;
  logic [FRAC_BITS-1:0] frac_acc_r, frac_acc_nxt;
  logic [FDIG_BITS-1:0] frac_digits_r, frac_digits_nxt;
  logic                 negative_r, negative_nxt;
  logic                 point_seen_r, point_seen_nxt;
  logic                 at_start_r;
  err_code_t            err_r, err_nxt;

  logic                 res_free;
  logic                 is_digit;
  logic [3:0]           dig;
  logic [INT_BITS+3:0]  int_sum;
  logic [FRAC_BITS-1:0] weight;
  logic [FRAC_BITS+3:0] frac_prod;
  logic [FRAC_BITS-1:0] frac_sum;

  // a word without the end mark needs no room in the result register
  assign res_free = !res_vld_r || res_take;
  assign take     = vld && (!word.last || res_free);

  assign is_digit = word.ch inside {[CH_ZERO:CH_NINE]};
  assign dig      = 4'(word.ch - CH_ZERO);

  // integer digit: acc*10 + d, saturating
  assign int_sum = {1'b0, int_acc_r, 3'b000} + {3'b000, int_acc_r, 1'b0} +
                   (INT_BITS+4)'(dig);

  // fraction digit: weight * d folded into the fraction accumulator
  always_comb begin
    weight = '0;
    if (frac_digits_r < FDIG_BITS'(MAX_FRAC_DIGITS)) begin
      weight = FRAC_W[frac_digits_r];
    end
  end
  assign frac_prod = weight * dig;
  assign frac_sum  = frac_acc_r + frac_prod[FRAC_BITS-1:0];

  // next parse state
  always_comb begin
    int_acc_nxt     = int_acc_r;
    frac_acc_nxt    = frac_acc_r;
    frac_digits_nxt = frac_digits_r;
    negative_nxt    = negative_r;
    point_seen_nxt  = point_seen_r;
    err_nxt         = err_r;
    if (is_digit) begin
      if (!point_seen_r) begin
        int_acc_nxt = (int_sum > INT_LIMIT) ? INT_LIMIT[INT_BITS-1:0] : int_sum[INT_BITS-1:0];
      end else if (frac_digits_r < FDIG_BITS'(MAX_FRAC_DIGITS)) begin
        frac_acc_nxt    = frac_sum;
        frac_digits_nxt = frac_digits_r + FDIG_BITS'(1);
      end
    end else if (word.ch == CH_POINT) begin
      if (point_seen_r) begin
        if (err_r == ERR_NONE) err_nxt = ERR_PLACEMENT;
      end else begin
        point_seen_nxt = 1'b1;
      end
    end else if (word.ch == CH_MINUS || word.ch == CH_PLUS) begin
      if (at_start_r) begin
        if (word.ch == CH_MINUS) negative_nxt = 1'b1;
      end else if (err_r == ERR_NONE) begin
        err_nxt = ERR_PLACEMENT;
      end
    end else if (err_r == ERR_NONE) begin
      err_nxt = ERR_BAD_CHAR;
    end
  end

  // parse state, cleared after the marked last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_acc_r     <= '0;
      frac_acc_r    <= '0;
      frac_digits_r <= '0;
      negative_r    <= 1'b0;
      point_seen_r  <= 1'b0;
      at_start_r    <= 1'b1;
      err_r         <= ERR_NONE;
    end else if (take) begin
      if (word.last) begin
        int_acc_r     <= '0;
        frac_acc_r    <= '0;
        frac_digits_r <= '0;
        negative_r    <= 1'b0;
        point_seen_r  <= 1'b0;
        at_start_r    <= 1'b1;
        err_r         <= ERR_NONE;
      end else begin
        int_acc_r     <= int_acc_nxt;
        frac_acc_r    <= frac_acc_nxt;
        frac_digits_r <= frac_digits_nxt;
        negative_r    <= negative_nxt;
        point_seen_r  <= point_seen_nxt;
        at_start_r    <= 1'b0;
        err_r         <= err_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (take && word.last) begin
      res_vld_r <= 1'b1;
    end else if (res_take) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && word.last) begin
      res_r.mag      <= {int_acc_nxt, frac_acc_nxt};
      res_r.negative <= negative_nxt;
      res_r.err      <= err_nxt;
    end
  end

endmodule

[hw/rtl/dtf_out.sv]
// sign application and output register
module dtf_out
  import dtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_vld,
  input  res_t      res,
  output logic      res_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic                  out_vld_r;
  out_word_t             out_word_r;
  logic [VALUE_BITS-1:0] mag_ext;
  logic [VALUE_BITS-1:0] value_nxt;

  assign res_take = res_vld && (!out_vld_r || !out_stall);

  // two's complement when negative, zero on any error
  assign mag_ext = VALUE_BITS'(res.mag);
  always_comb begin
    if (res.err != ERR_NONE) begin
      value_nxt = '0;
    end else if (res.negative) begin
      value_nxt = ~mag_ext + VALUE_BITS'(1);
    end else begin
      value_nxt = mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r.value      <= value_nxt;
      out_word_r.error_code <= res.err;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

[hw/rtl/decimal_text_to_fixed_top.sv]
// top level of the ascii decimal text to q31.32 fixed point converter
//
//   port group  dir  word       meaning
//   in_         in   in_word_t  one character, last marks end of string
//   out_        out  out_word_t signed q31.32 value and error code
//
// one character per cycle while in_stall is low; a result passes through the
// accumulator register, then the output register, once its marked last character is taken.
// the combinational character update (multiply by ten, weight multiply-add)
// sets the cycle time. synchronous active-low reset clears the valid flags and parse state.
// in_stall rises only when words are held up behind a stalled result.
module decimal_text_to_fixed_top
  import dtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic     in_vld_r;
  in_word_t in_word_r;
  logic     take;
  logic     res_vld;
  res_t     res;
  logic     res_take;

  dtf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (take),
    .vld_r    (in_vld_r),
    .word_r   (in_word_r)
  );

  dtf_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (in_vld_r),
    .word      (in_word_r),
    .take      (take),
    .res_take  (res_take),
    .res_vld_r (res_vld),
    .res_r     (res)
  );

  dtf_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[tb/tb_top.sv]
// self-checking testbench for the ascii decimal text to q31.32 converter
module tb_top;
  import dtf_pkg::*;

  typedef logic [7:0] text_t[$];

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // number being parsed, as the converter should see it
  logic [INT_BITS-1:0]  num_int = '0;
  logic [FRAC_BITS-1:0] num_frac = '0;
  int                   num_fdigits = 0;
  logic                 num_neg = 1'b0;
  logic                 num_point = 1'b0;
  logic                 num_first = 1'b1;
  err_code_t            num_err = ERR_NONE;

  out_word_t expected_values[$];
  int        mismatches = 0;

  // idling and hold-off controls
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_len = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cnt = 0;

  decimal_text_to_fixed_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task clear_number();
    num_int = '0;
    num_frac = '0;
    num_fdigits = 0;
    num_neg = 1'b0;
    num_point = 1'b0;
    num_first = 1'b1;
    num_err = ERR_NONE;
  endtask

  // advance the parse by one accepted word, queue the value on the last one
  task parse_word(input in_word_t w);
    logic [63:0]           next_int;
    logic [63:0]           pow;
    logic [63:0]           weight;
    logic [63:0]           sum;
    logic [VALUE_BITS-1:0] mag;
    logic [7:0]            d;
    logic                  first;
    out_word_t             res;
    first = num_first;
    num_first = 1'b0;
    if (w.ch >= CH_ZERO && w.ch <= CH_NINE) begin
      d = w.ch - CH_ZERO;
      if (!num_point) begin
        // integer part saturates at all ones
        next_int = 64'(num_int) * 64'd10 + 64'(d);
        if (next_int > ((64'd1 << INT_BITS) - 64'd1))
          num_int = '1;
        else
          num_int = next_int[INT_BITS-1:0];
      end else if (num_fdigits < MAX_FRAC_DIGITS) begin
        // truncated weight 2^frac / 10^k
        pow = 64'd10;
        repeat (num_fdigits) pow = pow * 64'd10;
        weight = (64'd1 << FRAC_BITS) / pow;
        sum = 64'(num_frac) + 64'(d) * weight;
        num_frac = sum[FRAC_BITS-1:0];
        num_fdigits++;
      end
    end else if (w.ch == CH_POINT) begin
      if (num_point) begin
        if (num_err == ERR_NONE) num_err = ERR_PLACEMENT;
      end else begin
        num_point = 1'b1;
      end
    end else if (w.ch == CH_MINUS || w.ch == CH_PLUS) begin
      if (first) begin
        if (w.ch == CH_MINUS) num_neg = 1'b1;
      end else if (num_err == ERR_NONE) begin
        num_err = ERR_PLACEMENT;
      end
    end else if (num_err == ERR_NONE) begin
      num_err = ERR_BAD_CHAR;
    end

    if (w.last) begin
      if (num_err != ERR_NONE) begin
        res.value = '0;
      end else begin
        mag = VALUE_BITS'({num_int, num_frac});
        res.value = num_neg ? -mag : mag;
      end
      res.error_code = num_err;
      expected_values.push_back(res);
      clear_number();
    end
  endtask

  // send one string, one character word per handshake, last on the final one
  task send_chars(input text_t chars);
    in_word_t w;
    for (int i = 0; i < chars.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      w.ch = chars[i];
      w.last = (i == chars.size() - 1);
      in_valid = 1'b1;
      in_word = w;
      do @(posedge clk); while (in_stall);
      parse_word(w);
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    text_t chars;
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_chars(chars);
  endtask

  // random number text: mostly well formed, some with a stray character, some noise
  function automatic text_t make_number();
    text_t      q;
    int         kind;
    int         n_int;
    logic [7:0] junk;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(3))
          0: q.push_back(8'($urandom_range(255)));
          1: q.push_back(CH_ZERO + 8'($urandom_range(9)));
          2: q.push_back(CH_POINT);
          default: q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        endcase
      end
      return q;
    end
    case ($urandom_range(3))
      0: q.push_back(CH_MINUS);
      1: q.push_back(CH_PLUS);
      default: ;
    endcase
    n_int = ($urandom_range(4) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
    repeat (n_int) q.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(9) < 7) begin
      q.push_back(CH_POINT);
      repeat ($urandom_range(0, 12)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    if (q.size() == 0) q.push_back(CH_ZERO);
    if (kind >= 80) begin
      case ($urandom_range(3))
        0: junk = CH_POINT;
        1: junk = CH_MINUS;
        2: junk = CH_PLUS;
        default: junk = 8'($urandom_range(255));
      endcase
      q.insert($urandom_range(q.size()), junk);
    end
    return q;
  endfunction

  // result side stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_cnt = hold_len;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each result word with the oldest expected value
  always @(posedge clk) begin : check_results
    out_word_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d code %0d",
                   out_word.value, out_word.error_code);
      end else begin
        exp_word = expected_values.pop_front();
        if (out_word.value !== exp_word.value ||
            out_word.error_code !== exp_word.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d code %0d, got value %0d code %0d",
                     exp_word.value, exp_word.error_code,
                     out_word.value, out_word.error_code);
        end
      end
    end
  end

  // field extremes, signs, points, saturation and every error kind
  task run_directed_strings();
    send_idle_pct = 0;
    stall_pct = 0;
    send_text("0");
    send_text("9");
    send_text("+");
    send_text("-");
    send_text(".");
    send_text("-0");
    send_text("+7.25");
    send_text("-.5");
    send_text("2147483647");
    send_text("2147483648");
    send_text("-99999999999.5");
    send_text("0.999999999");
    send_text("0.1234567890123");
    send_text("1.2.3");
    send_text("1-2");
    send_text("+-1");
    send_text("12a");
    send_text("a.5-");
    send_text("1..x");
    send_text("3.14 ");
    send_chars('{8'h00});
    send_chars('{8'hFF});
    send_chars('{CH_ZERO + 8'd1, 8'hFF});
    send_chars('{8'h7F, CH_MINUS});
  endtask

  task run_random_numbers(input int count, input int snd_pct, input int rcv_pct);
    text_t t;
    int    sent;
    send_idle_pct = snd_pct;
    stall_pct = rcv_pct;
    sent = 0;
    while (sent < count) begin
      t = make_number();
      send_chars(t);
      sent += t.size();
    end
  endtask

  // hold results back long enough that the block stalls its input
  task run_result_holdoff();
    text_t one;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 200;
    @(posedge clk);
    hold_go = ~hold_go;
    @(negedge clk);
    repeat (40) begin
      one = '{CH_ZERO + 8'($urandom_range(9))};
      send_chars(one);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed_strings();
    run_random_numbers(600, 8, 49);
    run_random_numbers(600, 49, 8);
    run_result_holdoff();
    run_random_numbers(600, 0, 0);
    in_valid = 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[decimal_text_to_fixed_top.f]
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_in_reg.sv
hw/rtl/dtf_accum.sv
hw/rtl/dtf_out.sv
hw/rtl/decimal_text_to_fixed_top.sv
tb/tb_top.sv
